// ===== design/bnt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnt_pkg
// Shared types, widths, microcode and constants of the band-pass noise and
// tone generator.
// ----------------------------------------------------------------------------
package bnt_pkg;

    // Sample and state formats
    localparam int SAMPLE_BITS = 16;              // Q1.15 noise input
    localparam int OUT_BITS    = 20;              // Q5.15 output
    localparam int STATE_BITS  = 24;              // Q3.21 filter levels
    localparam int STATE_FRAC  = 21;
    localparam int IN_SHIFT    = STATE_FRAC - (SAMPLE_BITS - 1);
    localparam int ALPHA_BITS  = 16;

    // Tone generation
    localparam int PHASE_W     = 32;
    localparam int SINE_DEPTH  = 1024;
    localparam int DEPTH_BITS  = $clog2(SINE_DEPTH);
    localparam int STEP_REGS   = 4;
    localparam int STEP_IDX_W  = $clog2(STEP_REGS);
    localparam int POLY_W      = 31;              // unsigned Q1.30 operands
    localparam int TONE_W      = SAMPLE_BITS;     // one signed sine value
    localparam int ACC_W       = TONE_W + STEP_IDX_W;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_BITS  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_A     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_B     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_C     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_D     = 3'd6;

    localparam logic [ALPHA_BITS-1:0] ALPHA_HIGH_RST = 16'hFFFF;

    typedef struct packed {
        logic [ALPHA_BITS-1:0]                 alpha_low;
        logic [ALPHA_BITS-1:0]                 alpha_high;
        logic [COUNT_BITS-1:0]                 tone_count;
        logic [STEP_REGS-1:0][PHASE_W-1:0]     steps;
    } bnt_cfg_t;

    // Sine polynomial coefficients, unsigned Q1.30
    localparam logic [POLY_W-1:0] COEF_VAL_C1 = 31'd1686629713;
    localparam logic [POLY_W-1:0] COEF_VAL_C3 = 31'd693598668;
    localparam logic [POLY_W-1:0] COEF_VAL_C5 = 31'd85569306;
    localparam logic [POLY_W-1:0] COEF_VAL_C7 = 31'd5026995;
    localparam logic [POLY_W-1:0] COEF_VAL_C9 = 31'd172272;

    // Coefficient selects in the control word
    localparam logic [1:0] COEF_C1 = 2'd0;
    localparam logic [1:0] COEF_C3 = 2'd1;
    localparam logic [1:0] COEF_C5 = 2'd2;
    localparam logic [1:0] COEF_C7 = 2'd3;

    function automatic logic [POLY_W-1:0] bnt_coef(input logic [1:0] sel);
        logic [POLY_W-1:0] c;
        begin
            case (sel)
                COEF_C1: c = COEF_VAL_C1;
                COEF_C3: c = COEF_VAL_C3;
                COEF_C5: c = COEF_VAL_C5;
                COEF_C7: c = COEF_VAL_C7;
                default: c = COEF_VAL_C1;
            endcase
            return c;
        end
    endfunction

    // Datapath operations
    localparam logic [3:0] OP_LOAD      = 4'd0;
    localparam logic [3:0] OP_DIFF_LOW  = 4'd1;
    localparam logic [3:0] OP_MUL_ALO   = 4'd2;
    localparam logic [3:0] OP_UPD_LOW   = 4'd3;
    localparam logic [3:0] OP_DIFF_HIGH = 4'd4;
    localparam logic [3:0] OP_MUL_AHI   = 4'd5;
    localparam logic [3:0] OP_UPD_HIGH  = 4'd6;
    localparam logic [3:0] OP_PHASE     = 4'd7;
    localparam logic [3:0] OP_MUL_XX    = 4'd8;
    localparam logic [3:0] OP_SET_X2    = 4'd9;
    localparam logic [3:0] OP_MUL_X2T   = 4'd10;
    localparam logic [3:0] OP_SUB_COEF  = 4'd11;
    localparam logic [3:0] OP_MUL_XT    = 4'd12;
    localparam logic [3:0] OP_SINE      = 4'd13;
    localparam logic [3:0] OP_ACC       = 4'd14;
    localparam logic [3:0] OP_EMIT      = 4'd15;

    // Jump conditions
    localparam logic [1:0] COND_NEXT       = 2'd0;
    localparam logic [1:0] COND_ALWAYS     = 2'd1;
    localparam logic [1:0] COND_TONES_DONE = 2'd2;
    localparam logic [1:0] COND_TONES_LEFT = 2'd3;

    // Program layout
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] STEP_IDLE = 5'd0;
    localparam logic [PC_W-1:0] STEP_TONE = 5'd7;
    localparam logic [PC_W-1:0] STEP_EMIT = 5'd21;

    typedef struct packed {
        logic [3:0]      op;
        logic [1:0]      coef;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } bnt_uword_t;

    typedef struct packed {
        logic stall;
        logic tones_done;
        logic tones_left;
    } bnt_flags_t;

    function automatic bnt_uword_t bnt_uw(input logic [3:0] op, input logic [1:0] coef,
                                          input logic [1:0] cond,
                                          input logic [PC_W-1:0] target);
        bnt_uword_t w;
        begin
            w.op     = op;
            w.coef   = coef;
            w.cond   = cond;
            w.target = target;
            return w;
        end
    endfunction

    // Microprogram: filter update, then one pass per active tone, then emit
    function automatic bnt_uword_t bnt_ucode(input logic [PC_W-1:0] pc);
        bnt_uword_t w;
        begin
            case (pc)
                5'd0:    w = bnt_uw(OP_LOAD,      COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd1:    w = bnt_uw(OP_DIFF_LOW,  COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd2:    w = bnt_uw(OP_MUL_ALO,   COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd3:    w = bnt_uw(OP_UPD_LOW,   COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd4:    w = bnt_uw(OP_DIFF_HIGH, COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd5:    w = bnt_uw(OP_MUL_AHI,   COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd6:    w = bnt_uw(OP_UPD_HIGH,  COEF_C1, COND_TONES_DONE, STEP_EMIT);
                5'd7:    w = bnt_uw(OP_PHASE,     COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd8:    w = bnt_uw(OP_MUL_XX,    COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd9:    w = bnt_uw(OP_SET_X2,    COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd10:   w = bnt_uw(OP_MUL_X2T,   COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd11:   w = bnt_uw(OP_SUB_COEF,  COEF_C7, COND_NEXT,       STEP_IDLE);
                5'd12:   w = bnt_uw(OP_MUL_X2T,   COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd13:   w = bnt_uw(OP_SUB_COEF,  COEF_C5, COND_NEXT,       STEP_IDLE);
                5'd14:   w = bnt_uw(OP_MUL_X2T,   COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd15:   w = bnt_uw(OP_SUB_COEF,  COEF_C3, COND_NEXT,       STEP_IDLE);
                5'd16:   w = bnt_uw(OP_MUL_X2T,   COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd17:   w = bnt_uw(OP_SUB_COEF,  COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd18:   w = bnt_uw(OP_MUL_XT,    COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd19:   w = bnt_uw(OP_SINE,      COEF_C1, COND_NEXT,       STEP_IDLE);
                5'd20:   w = bnt_uw(OP_ACC,       COEF_C1, COND_TONES_LEFT, STEP_TONE);
                5'd21:   w = bnt_uw(OP_EMIT,      COEF_C1, COND_ALWAYS,     STEP_IDLE);
                default: w = bnt_uw(OP_LOAD,      COEF_C1, COND_ALWAYS,     STEP_IDLE);
            endcase
            return w;
        end
    endfunction

endpackage

// ===== design/bnt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnt_stream_if
// Valid/ready channels: noise requests in, output samples out.
// ----------------------------------------------------------------------------
interface bnt_noise_if;
    import bnt_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] noise_in;
    logic                          final_tick;

    modport source (output valid, output noise_in, output final_tick, input ready);
    modport sink   (input valid, input noise_in, input final_tick, output ready);
endinterface

interface bnt_sample_if;
    import bnt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] sample_out;
    logic                       final_out;

    modport source (output valid, output sample_out, output final_out, input ready);
    modport sink   (input valid, input sample_out, input final_out, output ready);
endinterface

// ===== design/bandpass_noise_tone_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandpass_noise_tone_generator
// Band-limited noise (one-pole high-pass then one-pole low-pass) plus up to
// four phase-accumulator sine tones, saturated to a Q5.15 output.
// ----------------------------------------------------------------------------
// Each noise request yields one output sample: a microcoded sequencer walks
// one shared 32x32 multiplier through the two filter updates and six products
// per active tone. Input is taken only at the first step of the program; the
// result sits in an output register, so the next request is taken as soon as
// the previous result has been loaded there. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while idle, which the
// block itself does not enforce. The tone phase accumulators advance before
// the lookup and only for active tones.
module bandpass_noise_tone_generator #(
    parameter int MAX_TONES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bnt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bnt_pkg::CFG_DATA_W-1:0] cfg_data,
    bnt_noise_if.sink                      noise,
    bnt_sample_if.source                   sample
);
    import bnt_pkg::*;

    localparam int TONE_SLOTS = (MAX_TONES < STEP_REGS) ? MAX_TONES : STEP_REGS;

    bnt_cfg_t   cfg;
    bnt_uword_t ctl;
    bnt_flags_t flags;

    // Configuration registers
    bnt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Microprogram sequencer
    bnt_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    // Datapath
    bnt_datapath #(
        .TONE_SLOTS (TONE_SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (cfg),
        .flags  (flags),
        .noise  (noise),
        .sample (sample)
    );

endmodule

// ===== design/bnt_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnt_cfg_regs
// Write-only configuration registers: filter alphas, tone count, tone steps.
// ----------------------------------------------------------------------------
module bnt_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bnt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bnt_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bnt_pkg::bnt_cfg_t                  cfg
);
    import bnt_pkg::*;

    bnt_cfg_t cfg_reg;
    bnt_cfg_t cfg_next;

    // Decode one write; unknown index leaves everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHA_LOW:  cfg_next.alpha_low  = cfg_data[ALPHA_BITS-1:0];
                REG_ALPHA_HIGH: cfg_next.alpha_high = cfg_data[ALPHA_BITS-1:0];
                REG_TONE_COUNT: cfg_next.tone_count = cfg_data[COUNT_BITS-1:0];
                REG_STEP_A:     cfg_next.steps[0]   = cfg_data[PHASE_W-1:0];
                REG_STEP_B:     cfg_next.steps[1]   = cfg_data[PHASE_W-1:0];
                REG_STEP_C:     cfg_next.steps[2]   = cfg_data[PHASE_W-1:0];
                REG_STEP_D:     cfg_next.steps[3]   = cfg_data[PHASE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_low  <= '0;
            cfg_reg.alpha_high <= ALPHA_HIGH_RST;
            cfg_reg.tone_count <= '0;
            cfg_reg.steps      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/bnt_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnt_sequencer
// Step counter over the microcode ROM, with stall and conditional jumps.
// ----------------------------------------------------------------------------
module bnt_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bnt_pkg::bnt_flags_t  flags,
    output bnt_pkg::bnt_uword_t  ctl
);
    import bnt_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    // Control word of the current step
    assign ctl = bnt_ucode(pc_reg);

    // Jump condition
    always_comb
    begin
        case (ctl.cond)
            COND_NEXT:       take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_TONES_DONE: take = flags.tones_done;
            COND_TONES_LEFT: take = flags.tones_left;
            default:         take = 1'b0;
        endcase
    end

    // Hold on stall, else jump or advance
    always_comb
    begin
        if (flags.stall)
            pc_next = pc_reg;
        else if (take)
            pc_next = ctl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== design/bnt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnt_datapath
// Filter levels, phase accumulators, shared multiplier and output register,
// driven one operation per cycle by the microcode while no stall holds the step.
// ----------------------------------------------------------------------------
module bnt_datapath #(
    parameter int TONE_SLOTS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bnt_pkg::bnt_uword_t  ctl,
    input  bnt_pkg::bnt_cfg_t    cfg,
    output bnt_pkg::bnt_flags_t  flags,
    bnt_noise_if.sink            noise,
    bnt_sample_if.source         sample
);
    import bnt_pkg::*;

    localparam int J_W      = $clog2(TONE_SLOTS + 1);
    localparam int PH_IDX_W = (TONE_SLOTS > 1) ? $clog2(TONE_SLOTS) : 1;
    localparam int X_SHIFT  = (POLY_W - 1) - (DEPTH_BITS - 2);
    localparam int FRAC_W   = DEPTH_BITS - 2;
    localparam int DIFF_W   = STATE_BITS + 1;
    localparam int WIDE_W   = STATE_BITS + 4;
    localparam int RND_W    = DIFF_W + ALPHA_BITS + 2;
    localparam int HRND_W   = STATE_BITS + 1;
    localparam int SUM_W    = OUT_BITS + 1;
    localparam logic [TONE_W-2:0] TONE_TOP = '1;

    // Saturate a widened sum back to a filter level
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [WIDE_W-1:0] v);
        logic signed [STATE_BITS-1:0] r;
        begin
            if (v > $signed(WIDE_W'({1'b0, {(STATE_BITS-1){1'b1}}})))
                r = {1'b0, {(STATE_BITS-1){1'b1}}};
            else if (v < $signed({{(WIDE_W-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}}))
                r = {1'b1, {(STATE_BITS-1){1'b0}}};
            else
                r = v[STATE_BITS-1:0];
            return r;
        end
    endfunction

    // Saturate the final sum to the output width
    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [OUT_BITS-1:0] r;
        begin
            if (v[SUM_W-1] != v[SUM_W-2])
                r = v[SUM_W-1] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
            else
                r = v[OUT_BITS-1:0];
            return r;
        end
    endfunction

    // State with reset
    logic signed [STATE_BITS-1:0] low_reg, low_next;
    logic signed [STATE_BITS-1:0] high_reg, high_next;
    logic [PHASE_W-1:0]           phase_reg [TONE_SLOTS];
    logic [J_W-1:0]               j_reg, j_next;
    logic                         out_valid_reg, out_valid_next;

    // Working registers
    logic signed [STATE_BITS-1:0] s_reg, s_next;
    logic signed [DIFF_W-1:0]     d_reg, d_next;
    logic signed [63:0]           p_reg, p_next;
    logic [POLY_W-1:0]            x_reg, x_next;
    logic [POLY_W-1:0]            x2_reg, x2_next;
    logic [POLY_W-1:0]            t_reg, t_next;
    logic [1:0]                   quad_reg, quad_next;
    logic signed [TONE_W-1:0]     v_reg, v_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic                         final_reg, final_next;
    logic signed [OUT_BITS-1:0]   sample_reg, sample_next;
    logic                         fin_out_reg, fin_out_next;

    // Helpers
    logic signed [31:0]           mul_a, mul_b;
    logic [PH_IDX_W-1:0]          ph_idx;
    logic [STEP_IDX_W-1:0]        st_idx;
    logic [PHASE_W-1:0]           phase_sum;
    logic [DEPTH_BITS-1:0]        k;
    logic [FRAC_W:0]              xh;
    logic signed [RND_W-1:0]      rnd_sum;
    logic signed [STATE_BITS-1:0] hp;
    logic [31:0]                  sine_sum;
    logic [TONE_W:0]              sine_q;
    logic [TONE_W-2:0]            sine_mag;
    logic signed [HRND_W-1:0]     hrnd;
    logic [J_W-1:0]               active;
    logic [J_W:0]                 j_inc;
    logic                         out_busy;
    logic                         accept;

    assign ph_idx = PH_IDX_W'(j_reg);
    assign st_idx = STEP_IDX_W'(j_reg);
    assign active = (int'(cfg.tone_count) > TONE_SLOTS) ? J_W'(TONE_SLOTS)
                                                        : J_W'(cfg.tone_count);
    assign j_inc  = {1'b0, j_reg} + 1'b1;

    // Handshake
    assign noise.ready       = (ctl.op == OP_LOAD);
    assign accept            = noise.valid && noise.ready;
    assign out_busy          = out_valid_reg && !sample.ready;
    assign sample.valid      = out_valid_reg;
    assign sample.sample_out = sample_reg;
    assign sample.final_out  = fin_out_reg;

    assign flags.stall      = ((ctl.op == OP_LOAD) && !noise.valid) ||
                              ((ctl.op == OP_EMIT) && out_busy);
    assign flags.tones_done = (j_reg >= active);
    assign flags.tones_left = (j_inc < {1'b0, active});

    // Phase advance and quarter-wave fold
    assign phase_sum = phase_reg[ph_idx] + cfg.steps[st_idx];
    assign k         = phase_sum[PHASE_W-1 -: DEPTH_BITS];
    assign xh        = k[DEPTH_BITS-2] ? ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, k[FRAC_W-1:0]}
                                       : {1'b0, k[FRAC_W-1:0]};

    // Round-half-up of the filter product by 2^16
    assign rnd_sum = p_reg[RND_W-1:0] + RND_W'(32768);

    // High-pass input: input minus updated low-corner level
    assign hp = sat_state(WIDE_W'(s_reg) - WIDE_W'(low_reg));

    // Sine: round Q1.30 to Q1.15, clamp positive full scale
    assign sine_sum = p_reg[61:30] + 32'(1 << (30 - SAMPLE_BITS));
    assign sine_q   = sine_sum[31 - SAMPLE_BITS +: TONE_W + 1];
    assign sine_mag = (sine_q > (TONE_W+1)'(TONE_TOP)) ? TONE_TOP : sine_q[TONE_W-2:0];

    // Output rounding of the high-corner level to Q1.15
    assign hrnd = HRND_W'(high_reg) + HRND_W'(1 << (IN_SHIFT - 1));

    // One operation per step
    always_comb
    begin
        low_next       = low_reg;
        high_next      = high_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !sample.ready;
        s_next         = s_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        quad_next      = quad_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        final_next     = final_reg;
        sample_next    = sample_reg;
        fin_out_next   = fin_out_reg;
        mul_a          = '0;
        mul_b          = '0;
        case (ctl.op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    s_next     = STATE_BITS'(noise.noise_in) <<< IN_SHIFT;
                    final_next = noise.final_tick;
                    acc_next   = '0;
                    j_next     = '0;
                end
            end
            OP_DIFF_LOW:  d_next = DIFF_W'(s_reg) - DIFF_W'(low_reg);
            OP_MUL_ALO:
            begin
                mul_a  = 32'(d_reg);
                mul_b  = $signed({16'b0, cfg.alpha_low});
                p_next = mul_a * mul_b;
            end
            OP_UPD_LOW:
                low_next = sat_state(WIDE_W'(low_reg) +
                                     WIDE_W'($signed(rnd_sum[RND_W-1:16])));
            OP_DIFF_HIGH: d_next = DIFF_W'(hp) - DIFF_W'(high_reg);
            OP_MUL_AHI:
            begin
                mul_a  = 32'(d_reg);
                mul_b  = $signed({16'b0, cfg.alpha_high});
                p_next = mul_a * mul_b;
            end
            OP_UPD_HIGH:
                high_next = sat_state(WIDE_W'(high_reg) +
                                      WIDE_W'($signed(rnd_sum[RND_W-1:16])));
            OP_PHASE:
            begin
                quad_next = k[DEPTH_BITS-1 -: 2];
                x_next    = POLY_W'(xh) << X_SHIFT;
            end
            OP_MUL_XX:
            begin
                mul_a  = $signed({1'b0, x_reg});
                mul_b  = $signed({1'b0, x_reg});
                p_next = mul_a * mul_b;
            end
            OP_SET_X2:
            begin
                x2_next = p_reg[60:30];
                t_next  = COEF_VAL_C9;
            end
            OP_MUL_X2T:
            begin
                mul_a  = $signed({1'b0, x2_reg});
                mul_b  = $signed({1'b0, t_reg});
                p_next = mul_a * mul_b;
            end
            OP_SUB_COEF:  t_next = bnt_coef(ctl.coef) - p_reg[60:30];
            OP_MUL_XT:
            begin
                mul_a  = $signed({1'b0, x_reg});
                mul_b  = $signed({1'b0, t_reg});
                p_next = mul_a * mul_b;
            end
            OP_SINE:
                v_next = quad_reg[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
            OP_ACC:
            begin
                acc_next = acc_reg + ACC_W'(v_reg);
                j_next   = j_inc[J_W-1:0];
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sat_out(SUM_W'(acc_reg) +
                                             SUM_W'($signed(hrnd[HRND_W-1:IN_SHIFT])));
                    fin_out_next   = final_reg;
                end
            end
            default: ;
        endcase
    end

    // Filter levels, phases and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= '0;
            high_reg      <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TONE_SLOTS; i++)
                phase_reg[i] <= '0;
        end
        else
        begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (ctl.op == OP_PHASE)
                phase_reg[ph_idx] <= phase_sum;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        d_reg       <= d_next;
        p_reg       <= p_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        t_reg       <= t_next;
        quad_reg    <= quad_next;
        v_reg       <= v_next;
        acc_reg     <= acc_next;
        final_reg   <= final_next;
        sample_reg  <= sample_next;
        fin_out_reg <= fin_out_next;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the band-pass noise and tone generator against a cycle-free
// predictor. It covers filter updates, phase accumulators, sine polynomial,
// saturation and last-flag copy across many register settings, with random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import bnt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int IDLE_PERCENT  = 28;
    localparam int HOLD_OFF      = 400;
    localparam int TAIL_CYCLES   = 200;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 112;

    // Expected output sample and its copied last flag
    typedef struct packed {
        logic signed [OUT_BITS-1:0] level;
        logic                       last;
    } mix_sample_t;

    // ------------------------------------------------------------------------
    // Predictor and scoreboard: filter state, tone phases, pending samples
    // ------------------------------------------------------------------------
    class noise_tone_checker;
        localparam longint unsigned TABLE_DEPTH = 1024;
        localparam longint unsigned Q30_ONE     = 64'd1 << 30;
        localparam longint unsigned SIN_K1      = 64'd1686629713;
        localparam longint unsigned SIN_K3      = 64'd693598668;
        localparam longint unsigned SIN_K5      = 64'd85569306;
        localparam longint unsigned SIN_K7      = 64'd5026995;
        localparam longint unsigned SIN_K9      = 64'd172272;

        longint      alpha_low;
        longint      alpha_high;
        int          active_tones;
        logic [31:0] tone_steps [STEP_REGS];
        longint      low_level;
        longint      high_level;
        logic [31:0] tone_phase [STEP_REGS];
        mix_sample_t expected_samples [$];
        int          mismatches;
        int          accepted_noise;
        int          checked_samples;

        function new();
            alpha_low    = 0;
            alpha_high   = 65535;
            active_tones = 0;
            low_level    = 0;
            high_level   = 0;
            mismatches   = 0;
            accepted_noise  = 0;
            checked_samples = 0;
            for (int j = 0; j < STEP_REGS; j++)
            begin
                tone_steps[j] = '0;
                tone_phase[j] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_ALPHA_LOW:  alpha_low    = longint'(value[ALPHA_BITS-1:0]);
                REG_ALPHA_HIGH: alpha_high   = longint'(value[ALPHA_BITS-1:0]);
                REG_TONE_COUNT: active_tones = int'(value[COUNT_BITS-1:0]);
                REG_STEP_A:     tone_steps[0] = value;
                REG_STEP_B:     tone_steps[1] = value;
                REG_STEP_C:     tone_steps[2] = value;
                REG_STEP_D:     tone_steps[3] = value;
                default:        ;
            endcase
        endfunction

        // floor((v + 2^(sh-1)) / 2^sh)
        function longint round_shift(longint v, int sh);
            return (v + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function longint clamp_bits(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        // Quarter-wave folded odd polynomial, Q1.30 with floor per product
        function int sine_of(logic [31:0] phase);
            longint unsigned p, k, q4, r, x, x2, t, s;
            longint          v;
            int              quad;
            p    = phase;
            k    = (p * TABLE_DEPTH) >> 32;
            q4   = k * 4;
            quad = int'((q4 / TABLE_DEPTH) & 64'd3);
            r    = q4 % TABLE_DEPTH;
            x    = (r << 30) / TABLE_DEPTH;
            if (quad[0])
                x = Q30_ONE - x;
            x2 = (x * x) >> 30;
            t  = SIN_K7 - ((x2 * SIN_K9) >> 30);
            t  = SIN_K5 - ((x2 * t) >> 30);
            t  = SIN_K3 - ((x2 * t) >> 30);
            t  = SIN_K1 - ((x2 * t) >> 30);
            s  = (x * t) >> 30;
            v  = longint'((s + (64'd1 << 14)) >> 15);
            if (v > 32767)
                v = 32767;
            return (quad >= 2) ? int'(-v) : int'(v);
        endfunction

        // One accepted noise request: advance the state, queue the sample
        function void note_noise(logic signed [SAMPLE_BITS-1:0] noise, logic last);
            longint      scaled;
            longint      hp;
            longint      acc;
            int          tones;
            mix_sample_t item;
            scaled     = longint'(noise) * 64;
            low_level  = clamp_bits(low_level +
                round_shift((scaled - low_level) * alpha_low, 16), STATE_BITS);
            hp         = clamp_bits(scaled - low_level, STATE_BITS);
            high_level = clamp_bits(high_level +
                round_shift((hp - high_level) * alpha_high, 16), STATE_BITS);
            // counts above four use all four tones
            tones = (active_tones > STEP_REGS) ? STEP_REGS : active_tones;
            acc   = 0;
            for (int j = 0; j < tones; j++)
            begin
                tone_phase[j] = tone_phase[j] + tone_steps[j];
                acc += sine_of(tone_phase[j]);
            end
            acc        = clamp_bits(acc + round_shift(high_level, 6), OUT_BITS);
            item.level = acc[OUT_BITS-1:0];
            item.last  = last;
            expected_samples = {expected_samples, item};
            accepted_noise++;
        endfunction

        function void check_sample(logic signed [OUT_BITS-1:0] level, logic last);
            mix_sample_t want;
            if (expected_samples.size() == 0)
            begin
                $error("sample_out with nothing pending: actual %0d", level);
                mismatches++;
                return;
            end
            want = expected_samples.pop_front();
            checked_samples++;
            if (level !== want.level)
            begin
                $error("sample_out mismatch: expected %0d, actual %0d", want.level, level);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("final_out mismatch: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_samples.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bnt_noise_if  noise_ch ();
    bnt_sample_if sample_ch ();

    noise_tone_checker mix_check = new();

    int idle_percent = IDLE_PERCENT;
    int hold_request = 0;
    int settings_used = 1;

    bandpass_noise_tone_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .noise     (noise_ch),
        .sample    (sample_ch)
    );

    always #2 clk = ~clk;

    // Watch both channels at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (noise_ch.valid && noise_ch.ready)
                mix_check.note_noise(noise_ch.noise_in, noise_ch.final_tick);
            if (sample_ch.valid && sample_ch.ready)
                mix_check.check_sample(sample_ch.sample_out, sample_ch.final_out);
        end
    end

    // Receiver: random ready, with an optional long hold-off
    initial
    begin
        int stall_left;
        stall_left      = 0;
        sample_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                sample_ch.ready <= 1'b0;
            end
            else
                sample_ch.ready <= ($urandom_range(0, 99) >= idle_percent);
        end
    end

    // Offer one noise request, with random idle cycles ahead of it
    task automatic send_noise(input logic signed [SAMPLE_BITS-1:0] noise, input logic last);
        while ($urandom_range(0, 99) < idle_percent)
        begin
            noise_ch.valid <= 1'b0;
            @(posedge clk);
        end
        noise_ch.valid      <= 1'b1;
        noise_ch.noise_in   <= noise;
        noise_ch.final_tick <= last;
        do
            @(posedge clk);
        while (noise_ch.ready !== 1'b1);
    endtask

    // Drop valid and wait for every pending sample
    task automatic drain_samples();
        noise_ch.valid <= 1'b0;
        // let the monitor log the last accepted request first
        @(posedge clk);
        while (mix_check.outstanding() != 0)
            @(posedge clk);
    endtask

    // Write all registers in index order; optionally poke the unused index
    task automatic program_settings(input logic [CFG_DATA_W-1:0] a_lo, a_hi, count,
                                    input logic [CFG_DATA_W-1:0] s0, s1, s2, s3,
                                    input logic poke_unused);
        logic [CFG_DATA_W-1:0] values [8];
        values[REG_ALPHA_LOW]  = a_lo;
        values[REG_ALPHA_HIGH] = a_hi;
        values[REG_TONE_COUNT] = count;
        values[REG_STEP_A]     = s0;
        values[REG_STEP_B]     = s1;
        values[REG_STEP_C]     = s2;
        values[REG_STEP_D]     = s3;
        values[REG_UNUSED]     = $urandom;
        for (int i = REG_ALPHA_LOW; i <= REG_STEP_D; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
            mix_check.set_register(CFG_IDX_W'(i), values[i]);
        end
        if (poke_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data  <= values[REG_UNUSED];
            @(posedge clk);
            mix_check.set_register(REG_UNUSED, values[REG_UNUSED]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_alpha();
        logic [ALPHA_BITS-1:0] a;
        case ($urandom_range(0, 5))
            0:       a = '0;
            1:       a = '1;
            2:       a = 16'd1;
            default: a = ALPHA_BITS'($urandom);
        endcase
        // upper bits are don't-care for the register
        return {16'($urandom), a};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1 << 24);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 1 << 24);
            default: return {10'($urandom), 22'd0};
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_noise();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Stimulus
    initial
    begin
        noise_ch.valid      = 1'b0;
        noise_ch.noise_in   = '0;
        noise_ch.final_tick = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: low corner frozen, high corner passes, no tones
        send_noise(16'sh7FFF, 1'b0);
        send_noise(-16'sh8000, 1'b0);
        send_noise(16'sh0000, 1'b0);
        send_noise(-16'sh0001, 1'b1);
        send_noise(16'sh0001, 1'b0);
        send_noise(16'sh7FFF, 1'b1);
        drain_samples();

        // Tone count above four, high alpha zero, unused index written
        program_settings(32'h0000_FFFF, 32'h0, 32'd7, 32'h4000_0000, 32'hFFFF_FFFF,
                         32'h0, 32'h8000_0000, 1'b1);
        for (int i = 0; i < 8; i++)
            send_noise(i[0] ? -16'sh8000 : 16'sh7FFF, i[0]);
        drain_samples();

        // Both alphas zero; two tones so the others must hold their phase
        program_settings(32'h0, 32'h0, 32'd2, 32'h0040_0000, 32'h1234_5678,
                         32'h0100_0000, 32'h7FFF_FFFF, 1'b0);
        for (int i = 0; i < 5; i++)
            send_noise(pick_noise(), 1'b0);
        drain_samples();

        // All four tones, slow low corner, full high corner, extreme swings
        program_settings(32'h1, 32'hFFFF, 32'd4, 32'h0040_0000, 32'hC000_0000,
                         32'h2000_0000, 32'hFFC0_0000, 1'b0);
        for (int i = 0; i < 6; i++)
            send_noise(i[0] ? 16'sh7FFF : -16'sh8000, i == 5);
        drain_samples();

        // Random settings and noise
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            program_settings(pick_alpha(), pick_alpha(),
                             {29'($urandom), 3'($urandom_range(0, 7))},
                             pick_step(), pick_step(), pick_step(), pick_step(),
                             ($urandom_range(0, 3) == 0));
            idle_percent = (ph == 5) ? 0 : IDLE_PERCENT;
            if (ph == 3)
                hold_request = HOLD_OFF;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_noise(pick_noise(), ($urandom_range(0, 7) == 0));
            drain_samples();
        end
        idle_percent = IDLE_PERCENT;

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d noise requests over %0d register settings;",
                 mix_check.accepted_noise, settings_used);
        $display("%0d output samples checked, %0d mismatches.",
                 mix_check.checked_samples, mix_check.mismatches);
        if (mix_check.mismatches == 0 && mix_check.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d samples pending", mix_check.outstanding());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/bnt_pkg.sv
design/bnt_stream_if.sv
design/bnt_cfg_regs.sv
design/bnt_sequencer.sv
design/bnt_datapath.sv
design/bandpass_noise_tone_generator.sv
tb/testbench.sv
